FILE: rtl/a64x_pkg.sv
// a64x_pkg: shared types, command codes and constants of the AArch64 subset execute unit.
// No dependencies; imported by a64x_exec and the top level; its types are the channel payloads.
package a64x_pkg;

	localparam int NUM_REGS       = 32;
	localparam int REG_AW         = 5;
	localparam int DEF_RET_DEPTH  = 16;
	localparam logic [63:0] INSN_BYTES = 64'd4;

	localparam logic [3:0] CMD_BEGIN = 4'd0;
	localparam logic [3:0] CMD_ADD   = 4'd1;
	localparam logic [3:0] CMD_ADRP  = 4'd2;
	localparam logic [3:0] CMD_B     = 4'd3;
	localparam logic [3:0] CMD_BL    = 4'd4;
	localparam logic [3:0] CMD_BR    = 4'd5;
	localparam logic [3:0] CMD_CMP   = 4'd6;
	localparam logic [3:0] CMD_LDR   = 4'd7;
	localparam logic [3:0] CMD_LDP   = 4'd8;
	localparam logic [3:0] CMD_RET   = 4'd9;

	localparam logic [1:0] KIND_REG = 2'd0;
	localparam logic [1:0] KIND_IMM = 2'd1;

	localparam logic [2:0] BL_OPERANDS     = 3'd1;
	localparam logic [2:0] LDR_OFS_OPERANDS = 3'd3;

	typedef struct packed {
		logic [3:0]  command;
		logic [4:0]  reg_a;
		logic [4:0]  reg_b;
		logic [4:0]  reg_c;
		logic [1:0]  third_kind;
		logic [2:0]  operand_count;
		logic [63:0] immediate;
		logic [63:0] load_data;
		logic        load_failed;
	} in_item_t;

	typedef struct packed {
		logic [63:0] next_address;
		logic [63:0] load_address;
		logic        wrote_register;
		logic [63:0] written_value;
		logic        compare_equal;
		logic        reported;
		logic        stack_fault;
		logic        stack_empty;
	} out_item_t;

	// Commit controls produced by the execute logic.
	typedef struct packed {
		logic        wr_en;
		logic        push_en;
		logic [63:0] next_pc;
		logic        next_flag;
	} commit_t;

endpackage

FILE: rtl/a64x_chan_if.sv
// a64x_chan_if: valid/ready channel carrying one item of payload type T.
// Payload types come from a64x_pkg.
interface a64x_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/a64x_ram.sv
// a64x_ram: generic synchronous RAM, one write port, PORTS registered read ports.
// Read-first on a same-address write. No package dependency.
module a64x_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	parameter int PORTS = 1,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr [PORTS],
	output logic [WIDTH-1:0] rdata [PORTS]
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			for (int p = 0; p < PORTS; p++) begin
				rdata[p] <= mem[raddr[p]];
			end
		end
	end

endmodule

FILE: rtl/a64x_exec.sv
// a64x_exec: combinational execute of one instruction from its operands and the
// architectural state (pc, stack level, compare flag). Uses a64x_pkg.
module a64x_exec import a64x_pkg::*; #(
	parameter int RETURN_DEPTH = DEF_RET_DEPTH,
	localparam int LW = $clog2(RETURN_DEPTH + 1)
) (
	input  in_item_t    item,
	input  logic [63:0] op_b,
	input  logic [63:0] op_x,
	input  logic [63:0] stack_top,
	input  logic [63:0] pc,
	input  logic [LW-1:0] level,
	input  logic        flag,
	output out_item_t   res,
	output commit_t     cmt,
	output logic [LW-1:0] next_level
);

	logic [63:0] npc;
	logic [63:0] laddr;
	logic [63:0] wval;
	logic        wrote;
	logic        rep;
	logic        fault;
	logic        push;
	logic        nflag;
	logic [LW-1:0] nlvl;

	always_comb begin
		npc   = pc + INSN_BYTES;
		laddr = '0;
		wval  = '0;
		wrote = 1'b0;
		rep   = 1'b0;
		fault = 1'b0;
		push  = 1'b0;
		nflag = flag;
		nlvl  = level;
		case (item.command)
			CMD_BEGIN: begin
				npc   = item.immediate;
				nlvl  = '0;
				nflag = 1'b0;
			end
			CMD_ADD: begin
				if (item.third_kind == KIND_REG) begin
					wrote = 1'b1;
					wval  = op_b + op_x;
				end else if (item.third_kind == KIND_IMM) begin
					wrote = 1'b1;
					wval  = op_b + item.immediate;
				end else begin
					rep = 1'b1;
				end
			end
			CMD_ADRP: begin
				wrote = 1'b1;
				wval  = item.immediate;
			end
			CMD_B: begin
				npc = item.immediate;
			end
			CMD_BL: begin
				if (item.operand_count == BL_OPERANDS) begin
					if (level < LW'(RETURN_DEPTH)) begin
						push = 1'b1;
						nlvl = level + LW'(1);
					end else begin
						fault = 1'b1;
					end
					npc = item.immediate;
				end else begin
					rep = 1'b1;
				end
			end
			CMD_BR: begin
				npc = op_x;
			end
			CMD_CMP: begin
				nflag = (op_x == op_b);
			end
			CMD_LDR: begin
				laddr = (item.operand_count == LDR_OFS_OPERANDS) ? op_b + item.immediate
				                                                : op_b;
				wrote = 1'b1;
				if (item.load_failed) begin
					rep = 1'b1;
				end else begin
					wval = item.load_data;
				end
			end
			CMD_LDP: begin
			end
			CMD_RET: begin
				if (level != '0) begin
					nlvl = level - LW'(1);
					npc  = stack_top + INSN_BYTES;
				end else begin
					fault = 1'b1;
				end
			end
			default: begin
				rep = 1'b1;
			end
		endcase
	end

	assign res.next_address   = npc;
	assign res.load_address   = laddr;
	assign res.wrote_register = wrote;
	assign res.written_value  = wval;
	assign res.compare_equal  = nflag;
	assign res.reported       = rep;
	assign res.stack_fault    = fault;
	assign res.stack_empty    = (nlvl == '0);

	assign cmt.wr_en     = wrote;
	assign cmt.push_en   = push;
	assign cmt.next_pc   = npc;
	assign cmt.next_flag = nflag;
	assign next_level    = nlvl;

endmodule

FILE: rtl/arm64_subset_execute_unit.sv
// arm64_subset_execute_unit: top level; register file and return stack RAMs, read
// stage, execute/commit stage and output register. Uses a64x_pkg, a64x_chan_if,
// a64x_ram and a64x_exec.
//
//  channel  | dir | payload     | handshake
//  ---------+-----+-------------+--------------------------
//  instr    | in  | in_item_t   | valid/ready, sink modport
//  result   | out | out_item_t  | valid/ready, source modport
//
// One item per cycle unless the output stalls; an item is registered for execute, its result in the output register.
// The accepting edge reads the register file (two ports) and the return stack top;
// the next cycle executes, and the edge that advances it writes back, commits pc/level/flag
// and loads the output register, with forwarding of a write made at the read edge.
// Reset clears pc, stack level, flag and the register-file valid bits (unwritten
// registers read zero); no clearing pass. A stalled output holds the execute stage,
// which holds the input.
module arm64_subset_execute_unit import a64x_pkg::*; #(
	parameter int RETURN_DEPTH = DEF_RET_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	a64x_chan_if.sink   instr,
	a64x_chan_if.source result
);

	localparam int LW = $clog2(RETURN_DEPTH + 1);
	localparam int AW = $clog2(RETURN_DEPTH);

	logic          acc;
	logic          adv;
	logic          v_s1;
	in_item_t      item_s1;
	out_item_t     res;
	commit_t       cmt;
	logic [LW-1:0] nlvl;

	logic [63:0]   pc_q;
	logic [LW-1:0] level_q;
	logic          flag_q;
	logic [NUM_REGS-1:0] vld_q;

	out_item_t     out_q;
	logic          out_v_q;

	// register file
	logic [REG_AW-1:0] rf_raddr [2];
	logic [63:0]       rf_rdata [2];
	logic              vld_b_s1;
	logic              vld_x_s1;
	logic              byp_v_s1;
	logic [REG_AW-1:0] byp_a_s1;
	logic [63:0]       byp_d_s1;
	logic [REG_AW-1:0] x_addr_s1;
	logic [63:0]       op_b;
	logic [63:0]       op_x;

	// return stack
	logic [AW-1:0] st_raddr [1];
	logic [63:0]   st_rdata [1];
	logic [LW-1:0] lvl_after;
	logic [LW-1:0] lvl_m1;
	logic          st_byp_s1;
	logic [63:0]   st_byp_d_s1;
	logic [63:0]   stack_top;

	assign adv = v_s1 && (!out_v_q || result.ready);
	assign instr.ready = !v_s1 || adv;
	assign acc = instr.valid && instr.ready;

	// port 1 serves reg_c for add, reg_a for br/cmp
	assign rf_raddr[0] = instr.data.reg_b;
	assign rf_raddr[1] = (instr.data.command == CMD_ADD) ? instr.data.reg_c : instr.data.reg_a;
	assign x_addr_s1   = (item_s1.command == CMD_ADD) ? item_s1.reg_c : item_s1.reg_a;

	a64x_ram #(
		.WIDTH (64),
		.DEPTH (NUM_REGS),
		.PORTS (2)
	) u_regfile (
		.clk   (clk),
		.we    (adv && cmt.wr_en),
		.waddr (item_s1.reg_a),
		.wdata (res.written_value),
		.re    (acc),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	// stack level as it stands after this edge's commit
	assign lvl_after   = adv ? nlvl : level_q;
	assign lvl_m1      = lvl_after - LW'(1);
	assign st_raddr[0] = lvl_m1[AW-1:0];

	a64x_ram #(
		.WIDTH (64),
		.DEPTH (RETURN_DEPTH),
		.PORTS (1)
	) u_retstack (
		.clk   (clk),
		.we    (adv && cmt.push_en),
		.waddr (level_q[AW-1:0]),
		.wdata (pc_q),
		.re    (acc),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// read-stage capture: forwarding info for a write at the same edge as the read
	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1     <= instr.data;
			vld_b_s1    <= vld_q[rf_raddr[0]];
			vld_x_s1    <= vld_q[rf_raddr[1]];
			byp_a_s1    <= item_s1.reg_a;
			byp_d_s1    <= res.written_value;
			st_byp_d_s1 <= pc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			byp_v_s1  <= 1'b0;
			st_byp_s1 <= 1'b0;
		end else begin
			if (acc) begin
				v_s1      <= 1'b1;
				byp_v_s1  <= adv && cmt.wr_en;
				st_byp_s1 <= adv && cmt.push_en;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	assign op_b = (byp_v_s1 && byp_a_s1 == item_s1.reg_b) ? byp_d_s1 :
	              (vld_b_s1 ? rf_rdata[0] : 64'd0);
	assign op_x = (byp_v_s1 && byp_a_s1 == x_addr_s1) ? byp_d_s1 :
	              (vld_x_s1 ? rf_rdata[1] : 64'd0);
	assign stack_top = st_byp_s1 ? st_byp_d_s1 : st_rdata[0];

	a64x_exec #(
		.RETURN_DEPTH (RETURN_DEPTH)
	) u_exec (
		.item       (item_s1),
		.op_b       (op_b),
		.op_x       (op_x),
		.stack_top  (stack_top),
		.pc         (pc_q),
		.level      (level_q),
		.flag       (flag_q),
		.res        (res),
		.cmt        (cmt),
		.next_level (nlvl)
	);

	// architectural state commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			level_q <= '0;
			flag_q  <= 1'b0;
			vld_q   <= '0;
		end else if (adv) begin
			pc_q    <= cmt.next_pc;
			level_q <= nlvl;
			flag_q  <= cmt.next_flag;
			if (cmt.wr_en) begin
				vld_q[item_s1.reg_a] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;

endmodule
